[rtl/sitp_pkg.sv]
// shared types and constants for the segment intersection test and point unit
// no dependencies
`default_nettype none

package sitp_pkg;

  localparam int POINT_BITS = 48;

  // result request layout on the master side
  localparam int TOUCH_BIT  = 0;
  localparam int PAR_BIT    = 1;
  localparam int PX_LSB     = 2;
  localparam int PY_LSB     = PX_LSB + POINT_BITS;
  localparam int SAT_BIT    = PY_LSB + POINT_BITS;
  localparam int OUT_USED   = SAT_BIT + 1;
  localparam int OUT_BITS   = ((OUT_USED + 7) / 8) * 8;

  typedef struct packed {
    logic touch;
    logic parallel;
    logic neg_x;
    logic neg_y;
  } sitp_flags_t;

endpackage

`default_nettype wire

[rtl/segment_intersection_test_and_point_unit.sv]
// top level: geometry front end, divider pipeline, saturation and output skid
// depends on sitp_pkg, sitp_geom, sitp_prep, sitp_div_stage
//
//  channel  dir  tdata fields (lowest bit up)
//  s_*      in   first_start_x/y, first_end_x/y, second_start_x/y, second_end_x/y
//  m_*      out  segments_touch, lines_parallel, point_x, point_y, point_saturated
//
// one request per cycle while s_tready is high; each result passes the geometry and prep
// stages, then the one-bit-per-stage divider, then the output register
// rst clears every valid bit and the skid; no clearing pass
// a result waiting in the output register leaves s_tready high; the pipeline
// holds only once the skid register is also full
`default_nettype none

module segment_intersection_test_and_point_unit import sitp_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       s_tvalid,
  output logic                      s_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  wire  [8*COORD_BITS-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  wire                       m_tready,
  // segments_touch, lines_parallel, point_x, point_y, point_saturated, zero fill
  output logic [OUT_BITS-1:0]       m_tdata
);

  localparam int C  = COORD_BITS;
  localparam int XW = 2 * C + 3;
  localparam int DD = 2 * C + 4;
  localparam int NQ = 3 * C + 4 + FRAC_BITS;
  localparam int EW = (NQ > POINT_BITS) ? NQ + 1 : POINT_BITS + 1;

  logic                 en;
  logic                 skid_full;
  logic [OUT_BITS-1:0]  skid;

  logic                 g_valid, g_touch;
  logic signed [XW-1:0] g_a123, g_a124;
  logic signed [C-1:0]  g_sx, g_sy, g_ex, g_ey;

  logic                 d_valid [NQ+1];
  sitp_flags_t          d_flags [NQ+1];
  logic [DD-1:0]        d_den   [NQ+1];
  logic [DD-1:0]        d_rx    [NQ+1];
  logic [NQ-1:0]        d_qx    [NQ+1];
  logic [DD-1:0]        d_ry    [NQ+1];
  logic [NQ-1:0]        d_qy    [NQ+1];

  logic [POINT_BITS:0]  fx, fy;
  logic [OUT_BITS-1:0]  fin;
  logic                 fin_valid;

  assign en       = !skid_full;
  assign s_tready = en;

  sitp_geom #(.COORD_BITS(C)) u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .out_valid (g_valid),
    .out_touch (g_touch),
    .a123      (g_a123),
    .a124      (g_a124),
    .start_x   (g_sx),
    .start_y   (g_sy),
    .end_x     (g_ex),
    .end_y     (g_ey)
  );

  sitp_prep #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .in_touch  (g_touch),
    .a123      (g_a123),
    .a124      (g_a124),
    .start_x   (g_sx),
    .start_y   (g_sy),
    .end_x     (g_ex),
    .end_y     (g_ey),
    .out_valid (d_valid[0]),
    .out_flags (d_flags[0]),
    .den_mag   (d_den[0]),
    .num_x     (d_qx[0]),
    .num_y     (d_qy[0])
  );

  assign d_rx[0] = '0;
  assign d_ry[0] = '0;

  for (genvar i = 0; i < NQ; i++) begin : g_div
    sitp_div_stage #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (d_valid[i]),
      .in_flags  (d_flags[i]),
      .in_den    (d_den[i]),
      .in_rem_x  (d_rx[i]),
      .in_nq_x   (d_qx[i]),
      .in_rem_y  (d_ry[i]),
      .in_nq_y   (d_qy[i]),
      .out_valid (d_valid[i+1]),
      .out_flags (d_flags[i+1]),
      .out_den   (d_den[i+1]),
      .out_rem_x (d_rx[i+1]),
      .out_nq_x  (d_qx[i+1]),
      .out_rem_y (d_ry[i+1]),
      .out_nq_y  (d_qy[i+1])
    );
  end

  // apply sign, clamp to the point range; returns {saturated, value}
  function automatic logic [POINT_BITS:0] fix_point(input logic [NQ-1:0] mag,
                                                    input logic neg);
    logic [EW-1:0]         me;
    logic [EW-1:0]         lim;
    logic [POINT_BITS-1:0] v;
    logic                  s;
    me  = EW'(mag);
    lim = EW'(1) << (POINT_BITS - 1);
    v   = POINT_BITS'(mag);
    if (neg) begin
      v = -v;
      s = (me > lim);
    end else begin
      s = (me >= lim);
    end
    if (s) begin
      v = neg ? {1'b1, {(POINT_BITS-1){1'b0}}} : {1'b0, {(POINT_BITS-1){1'b1}}};
    end
    return {s, v};
  endfunction

  always_comb begin
    fx        = fix_point(d_qx[NQ], d_flags[NQ].neg_x);
    fy        = fix_point(d_qy[NQ], d_flags[NQ].neg_y);
    fin_valid = d_valid[NQ];
    fin       = '0;
    fin[TOUCH_BIT] = d_flags[NQ].touch;
    fin[PAR_BIT]   = d_flags[NQ].parallel;
    if (!d_flags[NQ].parallel) begin
      fin[PX_LSB +: POINT_BITS] = fx[POINT_BITS-1:0];
      fin[PY_LSB +: POINT_BITS] = fy[POINT_BITS-1:0];
      fin[SAT_BIT]              = fx[POINT_BITS] | fy[POINT_BITS];
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (m_tready) begin
        skid_full <= 1'b0;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= fin_valid;
    end else if (fin_valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (m_tready) begin
        m_tdata <= skid;
      end
    end else if (!m_tvalid || m_tready) begin
      m_tdata <= fin;
    end else begin
      skid <= fin;
    end
  end

endmodule

`default_nettype wire

[rtl/sitp_geom.sv]
// differences, cross and dot products, orientation signs and touch test
// depends on sitp_pkg
`default_nettype none

module sitp_geom import sitp_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           en,
  input  wire                           in_valid,
  input  wire  [8*COORD_BITS-1:0]       in_data,
  output logic                          out_valid,
  output logic                          out_touch,
  output logic signed [2*COORD_BITS+2:0] a123,
  output logic signed [2*COORD_BITS+2:0] a124,
  output logic signed [COORD_BITS-1:0]  start_x,
  output logic signed [COORD_BITS-1:0]  start_y,
  output logic signed [COORD_BITS-1:0]  end_x,
  output logic signed [COORD_BITS-1:0]  end_y
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * C + 2;
  localparam int XW = 2 * C + 3;

  // u = P[UA] - P[BS], v = P[VA] - P[BS]
  localparam int UA [8] = '{1, 1, 3, 3, 0, 0, 2, 2};
  localparam int VA [8] = '{2, 3, 0, 1, 1, 1, 3, 3};
  localparam int BS [8] = '{0, 0, 2, 2, 2, 3, 0, 1};

  logic signed [C-1:0]  cx [4];
  logic signed [C-1:0]  cy [4];

  logic                 v1;
  logic signed [DW-1:0] ux [8];
  logic signed [DW-1:0] uy [8];
  logic signed [DW-1:0] vx [8];
  logic signed [DW-1:0] vy [8];
  logic signed [C-1:0]  s1_sx, s1_sy, s1_ex, s1_ey;

  logic                 v2;
  logic signed [PW-1:0] pxy [8];
  logic signed [PW-1:0] pyx [8];
  logic signed [PW-1:0] dxx [4];
  logic signed [PW-1:0] dyy [4];
  logic signed [C-1:0]  s2_sx, s2_sy, s2_ex, s2_ey;

  logic signed [XW-1:0] cr [8];
  logic signed [XW-1:0] dt [4];
  logic [7:0]           zr, ng, ps;
  logic [3:0]           btw;
  logic                 touch_next;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cx[k] = in_data[(2*k)*C +: C];
      cy[k] = in_data[(2*k+1)*C +: C];
    end
  end

  // stage one: coordinate differences
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        ux[i] <= DW'(cx[UA[i]]) - DW'(cx[BS[i]]);
        uy[i] <= DW'(cy[UA[i]]) - DW'(cy[BS[i]]);
        vx[i] <= DW'(cx[VA[i]]) - DW'(cx[BS[i]]);
        vy[i] <= DW'(cy[VA[i]]) - DW'(cy[BS[i]]);
      end
      s1_sx <= cx[2];
      s1_sy <= cy[2];
      s1_ex <= cx[3];
      s1_ey <= cy[3];
    end
  end

  // stage two: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        pxy[i] <= PW'(ux[i]) * PW'(vy[i]);
        pyx[i] <= PW'(uy[i]) * PW'(vx[i]);
      end
      for (int j = 0; j < 4; j++) begin
        dxx[j] <= PW'(ux[4+j]) * PW'(vx[4+j]);
        dyy[j] <= PW'(uy[4+j]) * PW'(vy[4+j]);
      end
      s2_sx <= s1_sx;
      s2_sy <= s1_sy;
      s2_ex <= s1_ex;
      s2_ey <= s1_ey;
    end
  end

  // stage three: cross and dot sums, touch decision
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cr[i] = XW'(pxy[i]) - XW'(pyx[i]);
      zr[i] = (cr[i] == '0);
      ng[i] = cr[i][XW-1];
      ps[i] = !zr[i] && !ng[i];
    end
    for (int j = 0; j < 4; j++) begin
      dt[j]  = XW'(dxx[j]) + XW'(dyy[j]);
      btw[j] = zr[4+j] && (dt[j][XW-1] || dt[j] == '0);
    end
    if (zr[0] && zr[1]) begin
      touch_next = |btw;
    end else begin
      touch_next = !((ps[0] && ps[1]) || (ng[0] && ng[1])) &&
                   !((ps[2] && ps[3]) || (ng[2] && ng[3]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_touch <= touch_next;
      a123      <= cr[0];
      a124      <= cr[1];
      start_x   <= s2_sx;
      start_y   <= s2_sy;
      end_x     <= s2_ex;
      end_y     <= s2_ey;
    end
  end

endmodule

`default_nettype wire

[rtl/sitp_prep.sv]
// denominator, numerator products, scaling and magnitudes for the divider
// depends on sitp_pkg
`default_nettype none

module sitp_prep import sitp_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     en,
  input  wire                                     in_valid,
  input  wire                                     in_touch,
  input  wire  signed [2*COORD_BITS+2:0]          a123,
  input  wire  signed [2*COORD_BITS+2:0]          a124,
  input  wire  signed [COORD_BITS-1:0]            start_x,
  input  wire  signed [COORD_BITS-1:0]            start_y,
  input  wire  signed [COORD_BITS-1:0]            end_x,
  input  wire  signed [COORD_BITS-1:0]            end_y,
  output logic                                    out_valid,
  output sitp_flags_t                             out_flags,
  output logic [2*COORD_BITS+3:0]                 den_mag,
  output logic [3*COORD_BITS+3+FRAC_BITS:0]       num_x,
  output logic [3*COORD_BITS+3+FRAC_BITS:0]       num_y
);

  localparam int C  = COORD_BITS;
  localparam int DD = 2 * C + 4;
  localparam int MW = 3 * C + 3;
  localparam int NW = 3 * C + 4;
  localparam int NQ = NW + FRAC_BITS;

  logic                 v4, t4;
  logic signed [DD-1:0] den;
  logic signed [MW-1:0] mxa, mxb, mya, myb;

  logic signed [NW-1:0] nx, ny;
  logic signed [NQ-1:0] sx, sy;
  logic                 dneg;

  // stage four: denominator and numerator products
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4  <= in_touch;
      den <= DD'(a123) - DD'(a124);
      mxa <= MW'(end_x) * MW'(a123);
      mxb <= MW'(start_x) * MW'(a124);
      mya <= MW'(end_y) * MW'(a123);
      myb <= MW'(start_y) * MW'(a124);
    end
  end

  // stage five: scaled numerators, signs and magnitudes
  always_comb begin
    nx   = NW'(mxa) - NW'(mxb);
    ny   = NW'(mya) - NW'(myb);
    sx   = NQ'(nx) <<< FRAC_BITS;
    sy   = NQ'(ny) <<< FRAC_BITS;
    dneg = den[DD-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_flags.touch    <= t4;
      out_flags.parallel <= (den == '0);
      out_flags.neg_x    <= sx[NQ-1] ^ dneg;
      out_flags.neg_y    <= sy[NQ-1] ^ dneg;
      den_mag            <= dneg ? DD'(-den) : DD'(den);
      num_x              <= sx[NQ-1] ? NQ'(-sx) : NQ'(sx);
      num_y              <= sy[NQ-1] ? NQ'(-sy) : NQ'(sy);
    end
  end

endmodule

`default_nettype wire

[rtl/sitp_div_stage.sv]
// one restoring division step for both coordinates, registered
// depends on sitp_pkg
`default_nettype none

module sitp_div_stage import sitp_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 en,
  input  wire                                 in_valid,
  input  sitp_flags_t                         in_flags,
  input  wire  [2*COORD_BITS+3:0]             in_den,
  input  wire  [2*COORD_BITS+3:0]             in_rem_x,
  input  wire  [3*COORD_BITS+3+FRAC_BITS:0]   in_nq_x,
  input  wire  [2*COORD_BITS+3:0]             in_rem_y,
  input  wire  [3*COORD_BITS+3+FRAC_BITS:0]   in_nq_y,
  output logic                                out_valid,
  output sitp_flags_t                         out_flags,
  output logic [2*COORD_BITS+3:0]             out_den,
  output logic [2*COORD_BITS+3:0]             out_rem_x,
  output logic [3*COORD_BITS+3+FRAC_BITS:0]   out_nq_x,
  output logic [2*COORD_BITS+3:0]             out_rem_y,
  output logic [3*COORD_BITS+3+FRAC_BITS:0]   out_nq_y
);

  localparam int DD = 2 * COORD_BITS + 4;
  localparam int NQ = 3 * COORD_BITS + 4 + FRAC_BITS;

  logic [DD:0] tx, ty, dx;
  logic        gx, gy;

  // shift the next numerator bit into the remainder; quotient bits fill from below
  always_comb begin
    dx = {1'b0, in_den};
    tx = {in_rem_x, in_nq_x[NQ-1]};
    ty = {in_rem_y, in_nq_y[NQ-1]};
    gx = (tx >= dx);
    gy = (ty >= dx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_flags <= in_flags;
      out_den   <= in_den;
      out_rem_x <= gx ? DD'(tx - dx) : DD'(tx);
      out_rem_y <= gy ? DD'(ty - dx) : DD'(ty);
      out_nq_x  <= {in_nq_x[NQ-2:0], gx};
      out_nq_y  <= {in_nq_y[NQ-2:0], gy};
    end
  end

endmodule

`default_nettype wire

[rtl/sitp_checker.sv]
// port-level checks on the segment intersection unit, attached by bind
// depends on sitp_pkg
`default_nettype none

module sitp_checker import sitp_pkg::*; (
  input wire                     clk,
  input wire                     rst,
  input wire                     s_tready,
  input wire                     m_tvalid,
  input wire                     m_tready,
  input wire [OUT_BITS-1:0]      m_tdata
);

  // stalled result request holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // parallel lines give a zero point and no clamp
  a_par: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[PAR_BIT] |-> m_tdata[SAT_BIT:PX_LSB] == '0)
    else $error("parallel result with nonzero point");

  // fill bits stay zero
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_BITS-1:OUT_USED] == '0)
    else $error("fill bits set");

  // nothing leaves right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result after reset");

  // input side only stalls while a result is waiting
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

endmodule

bind segment_intersection_test_and_point_unit sitp_checker u_sitp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
